>>> rtl/signed_integer_to_radix_digits_defines.svh
// assertion macros for the radix digit converter
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef ASSERT_OFF
`define SITRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sitrd assertion failed");
`define SITRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sitrd assertion failed");
`else
`define SITRD_ASSERT(lbl, prop)
`define SITRD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/sitrd_pkg.sv
// types, constants and the digit table lookup for the radix digit converter
package sitrd_pkg;

  localparam int CHAR_W     = 8;
  localparam int NUM_CHARS  = 16;
  localparam int IDX_W      = 4;
  localparam int IN_W       = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int BASE_LEN_W = 5;
  localparam int CHUNK_W    = 8;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [BASE_LEN_W-1:0] base_len_t;
  typedef logic [CFG_W-1:0]      chars_t;

  localparam cfg_idx_t CFG_BASE_LENGTH = 2'd0;
  localparam cfg_idx_t CFG_CHARS_LOW   = 2'd1;
  localparam cfg_idx_t CFG_CHARS_HIGH  = 2'd2;

  localparam base_len_t RST_BASE_LENGTH = 5'd10;
  localparam chars_t    RST_CHARS_LOW   = 64'h3736353433323130;
  localparam chars_t    RST_CHARS_HIGH  = 64'h0000000000003938;

  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_TILDE = 8'h7E;

  function automatic char_t digit_char(input chars_t lo, input chars_t hi, input idx_t idx);
    logic [2*CFG_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

>>> rtl/sitrd_val_if.sv
// input channel: one signed value per item
interface sitrd_val_if;
  logic                          valid;
  logic                          ready;
  logic signed [sitrd_pkg::IN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/sitrd_chr_if.sv
// result channel: one text character per item
interface sitrd_chr_if;
  logic                  valid;
  logic                  ready;
  sitrd_pkg::char_t      character;
  logic                  last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/signed_integer_to_radix_digits.sv
// Signed integer to text in a configurable radix. An accepted value is written out most
// significant digit first, with a leading '-' when negative, one character per output item
// and last set on the final one; an invalid digit table gives no output at all. One value is
// handled at a time and in_ch.ready is low while it is in flight. Steps per item: accept, the
// digit table check (one character against the later ones per cycle), then the digits in the
// shared divide-by-radix unit, which retires eight quotient bits a cycle, then the characters
// one by one as the output is taken. An invalid table is dropped after at most the check pass.
`include "signed_integer_to_radix_digits_defines.svh"

module signed_integer_to_radix_digits #(
  parameter int MAX_RADIX   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sitrd_val_if.sink                        in_ch,
  sitrd_chr_if.source                      out_ch,
  input  logic                             cfg_we,
  input  sitrd_pkg::cfg_idx_t              cfg_index,
  input  logic [sitrd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int DW    = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int STEPS = (VALUE_WIDTH + sitrd_pkg::CHUNK_W - 1) / sitrd_pkg::CHUNK_W;
  localparam int PADW  = STEPS * sitrd_pkg::CHUNK_W;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int DEPTH = VALUE_WIDTH;
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // configuration
  sitrd_pkg::base_len_t base_length_r, base_length_nxt;
  sitrd_pkg::chars_t    chars_lo_r, chars_lo_nxt;
  sitrd_pkg::chars_t    chars_hi_r, chars_hi_nxt;

  // sequencer and datapath
  logic [1:0]           st_r, st_nxt;
  sitrd_pkg::idx_t      idx_r, idx_nxt;
  logic [SW-1:0]        stp_r, stp_nxt;
  logic [PADW-1:0]      div_r, div_nxt;
  logic [DW-1:0]        rem_r, rem_nxt;
  logic [DW:0]          radix_r, radix_nxt;
  logic                 neg_r, neg_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DW-1:0]        stk_r   [DEPTH];
  logic [DW-1:0]        stk_nxt [DEPTH];

  // output register
  logic                 out_valid_r, out_valid_nxt;
  sitrd_pkg::char_t     out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_acc;
  logic                 ld_out;
  logic                 emit_last;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                 len_ok;
  sitrd_pkg::char_t     cur_c;
  logic                 char_bad;
  logic                 dup;
  logic [DW-1:0]        rem_step;
  logic [sitrd_pkg::CHUNK_W-1:0] qbits;
  logic [sitrd_pkg::CHUNK_W-1:0] chunk;
  logic [DW:0]          trial;
  logic [PADW-1:0]      quot;

  assign in_ch.ready      = (st_r == ST_IDLE);
  assign in_acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  assign raw    = in_ch.value[VALUE_WIDTH-1:0];
  assign mag    = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
  assign len_ok = (base_length_r >= sitrd_pkg::BASE_LEN_W'(2)) &&
                  (base_length_r <= sitrd_pkg::BASE_LEN_W'(MAX_RADIX));

  // table check: character idx_r against the later characters of the table in use
  always_comb begin
    cur_c    = sitrd_pkg::digit_char(chars_lo_r, chars_hi_r, idx_r);
    char_bad = (cur_c == sitrd_pkg::CHAR_MINUS) || (cur_c == sitrd_pkg::CHAR_PLUS) ||
               (cur_c < sitrd_pkg::CHAR_SPACE) || (cur_c > sitrd_pkg::CHAR_TILDE);
    dup      = 1'b0;
    for (int j = 0; j < sitrd_pkg::NUM_CHARS; j++) begin
      if (((sitrd_pkg::IDX_W + 1)'(j) > {1'b0, idx_r}) &&
          (sitrd_pkg::BASE_LEN_W'(j) < base_length_r) &&
          (sitrd_pkg::digit_char(chars_lo_r, chars_hi_r, sitrd_pkg::IDX_W'(j)) == cur_c)) begin
        dup = 1'b1;
      end
    end
  end

  // shared divide unit: eight restoring steps on the narrow remainder
  always_comb begin
    chunk    = div_r[PADW-1 -: sitrd_pkg::CHUNK_W];
    rem_step = rem_r;
    qbits    = '0;
    trial    = '0;
    for (int k = sitrd_pkg::CHUNK_W - 1; k >= 0; k--) begin
      trial = {rem_step, chunk[k]};
      if (trial >= radix_r) begin
        trial    = trial - radix_r;
        qbits[k] = 1'b1;
      end
      rem_step = trial[DW-1:0];
    end
    quot = (div_r << sitrd_pkg::CHUNK_W) | PADW'(qbits);
  end

  assign ld_out    = (st_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign emit_last = !neg_r && (cnt_r == CW'(1));

  always_comb begin
    base_length_nxt = base_length_r;
    chars_lo_nxt    = chars_lo_r;
    chars_hi_nxt    = chars_hi_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sitrd_pkg::CFG_BASE_LENGTH: base_length_nxt = cfg_data[sitrd_pkg::BASE_LEN_W-1:0];
        sitrd_pkg::CFG_CHARS_LOW:   chars_lo_nxt    = cfg_data;
        sitrd_pkg::CFG_CHARS_HIGH:  chars_hi_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    stp_nxt       = stp_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    stk_nxt       = stk_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_nxt   = PADW'(mag);
          neg_nxt   = raw[VALUE_WIDTH-1];
          radix_nxt = base_length_r[DW:0];
          idx_nxt   = '0;
          stp_nxt   = '0;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          // bad length drops the item right away
          if (len_ok) begin
            st_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (char_bad || dup) begin
          st_nxt = ST_IDLE;
        end else if ({1'b0, idx_r} == base_length_r - sitrd_pkg::BASE_LEN_W'(1)) begin
          st_nxt = ST_DIV;
        end
        idx_nxt = idx_r + sitrd_pkg::IDX_W'(1);
      end
      ST_DIV: begin
        div_nxt = quot;
        rem_nxt = rem_step;
        stp_nxt = stp_r + SW'(1);
        if (stp_r == SW'(STEPS - 1)) begin
          // digit done: push it, go on with the quotient
          stk_nxt[0] = rem_step;
          for (int i = 1; i < DEPTH; i++) begin
            stk_nxt[i] = stk_r[i-1];
          end
          cnt_nxt = cnt_r + CW'(1);
          stp_nxt = '0;
          rem_nxt = '0;
          if (quot == '0) begin
            st_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (ld_out) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = sitrd_pkg::CHAR_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = sitrd_pkg::digit_char(chars_lo_r, chars_hi_r,
                                                 sitrd_pkg::IDX_W'(stk_r[0]));
            out_last_nxt = emit_last;
            for (int i = 0; i < DEPTH - 1; i++) begin
              stk_nxt[i] = stk_r[i+1];
            end
            cnt_nxt = cnt_r - CW'(1);
            if (emit_last) begin
              st_nxt = ST_IDLE;
            end
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= sitrd_pkg::RST_BASE_LENGTH;
      chars_lo_r    <= sitrd_pkg::RST_CHARS_LOW;
      chars_hi_r    <= sitrd_pkg::RST_CHARS_HIGH;
      st_r          <= ST_IDLE;
      idx_r         <= '0;
      stp_r         <= '0;
      cnt_r         <= '0;
      neg_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      base_length_r <= base_length_nxt;
      chars_lo_r    <= chars_lo_nxt;
      chars_hi_r    <= chars_hi_nxt;
      st_r          <= st_nxt;
      idx_r         <= idx_nxt;
      stp_r         <= stp_nxt;
      cnt_r         <= cnt_nxt;
      neg_r         <= neg_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    stk_r      <= stk_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // remainder of the running division never reaches the radix
  `SITRD_ASSERT(a_rem_below_radix, (st_r == ST_DIV) |-> ({1'b0, rem_r} < radix_r))
  // while characters go out there is always a digit left to send
  `SITRD_ASSERT(a_emit_has_digit, (st_r == ST_EMIT) |-> (cnt_r != '0))
  // the final character of an item returns the sequencer to idle
  `SITRD_ASSERT(a_last_to_idle, (ld_out && emit_last) |=> (st_r == ST_IDLE))
  // a minus sign is never the end of the text
  `SITRD_ASSERT(a_sign_not_last,
    (out_valid_r && (out_char_r == sitrd_pkg::CHAR_MINUS) && !out_last_r && (st_r == ST_EMIT))
      |-> (cnt_r != '0))
  // digit stack never overflows
  `SITRD_ASSERT_ALWAYS(a_cnt_range, !rst_n || (cnt_r <= CW'(DEPTH)))

endmodule

>>> tb/sv/signed_integer_to_radix_digits_checker.sv
// checker for the radix digit converter: predicts the text of each value and compares
module signed_integer_to_radix_digits_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  sitrd_val_if                 in_ch,
  sitrd_chr_if                 out_ch,
  input  logic                 cfg_we,
  input  sitrd_pkg::cfg_idx_t  cfg_index,
  input  sitrd_pkg::chars_t    cfg_data,
  output int                   mismatches,
  output int                   chars_pending
);

  typedef struct packed {
    sitrd_pkg::char_t character;
    logic             last;
  } text_char_t;

  sitrd_pkg::base_len_t radix_len;
  sitrd_pkg::chars_t    chars_lo;
  sitrd_pkg::chars_t    chars_hi;
  text_char_t           awaited_chars [$];

  function automatic sitrd_pkg::char_t table_char(input int idx);
    logic [2*sitrd_pkg::CFG_W-1:0] tbl;
    tbl = {chars_hi, chars_lo};
    return tbl[idx*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W];
  endfunction

  function automatic bit base_usable();
    sitrd_pkg::char_t c;
    if (radix_len < 2 || radix_len > sitrd_pkg::NUM_CHARS) return 1'b0;
    for (int i = 0; i < radix_len; i++) begin
      c = table_char(i);
      if (c == sitrd_pkg::CHAR_MINUS || c == sitrd_pkg::CHAR_PLUS) return 1'b0;
      if (c < sitrd_pkg::CHAR_SPACE || c > sitrd_pkg::CHAR_TILDE) return 1'b0;
      for (int j = i + 1; j < radix_len; j++)
        if (table_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queues the characters that one value turns into, most significant digit first
  function automatic void spell_value(input logic signed [sitrd_pkg::IN_W-1:0] v);
    logic [sitrd_pkg::IN_W-1:0] mag;
    logic [sitrd_pkg::IN_W-1:0] radix;
    sitrd_pkg::idx_t            digits [$];
    if (!base_usable()) return;
    radix = 32'(radix_len);
    // magnitude kept unsigned so the most negative value comes out right
    mag = v[sitrd_pkg::IN_W-1] ? (~v + 1'b1) : v;
    do begin
      digits.push_front(sitrd_pkg::idx_t'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (v[sitrd_pkg::IN_W-1])
      awaited_chars.push_back(text_char_t'{sitrd_pkg::CHAR_MINUS, 1'b0});
    foreach (digits[i])
      awaited_chars.push_back(text_char_t'{table_char(int'(digits[i])),
                                           i == digits.size() - 1});
  endfunction

  always @(posedge clk) begin
    text_char_t exp_char;
    if (!rst_n) begin
      radix_len  = sitrd_pkg::RST_BASE_LENGTH;
      chars_lo   = sitrd_pkg::RST_CHARS_LOW;
      chars_hi   = sitrd_pkg::RST_CHARS_HIGH;
      mismatches = 0;
      awaited_chars.delete();
    end else begin
      // an item accepted at this edge still sees the table from before it
      if (in_ch.valid && in_ch.ready) spell_value(in_ch.value);
      if (cfg_we) begin
        case (cfg_index)
          sitrd_pkg::CFG_BASE_LENGTH: radix_len = cfg_data[sitrd_pkg::BASE_LEN_W-1:0];
          sitrd_pkg::CFG_CHARS_LOW:   chars_lo  = cfg_data;
          sitrd_pkg::CFG_CHARS_HIGH:  chars_hi  = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t: expected nothing, got char %h last %0b",
                   $time, out_ch.character, out_ch.last);
          mismatches++;
        end else begin
          exp_char = awaited_chars.pop_front();
          if (out_ch.character !== exp_char.character || out_ch.last !== exp_char.last) begin
            $display("%0t: expected char %h last %0b, got char %h last %0b", $time,
                     exp_char.character, exp_char.last, out_ch.character, out_ch.last);
            mismatches++;
          end
        end
      end
    end
    chars_pending = awaited_chars.size();
  end

endmodule

>>> tb/sv/signed_integer_to_radix_digits_test.sv
// top of the radix digit converter testbench: clock, reset, stimulus and verdict
module signed_integer_to_radix_digits_test;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 200;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASE_ITEMS     = 120;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  sitrd_pkg::cfg_idx_t cfg_index;
  sitrd_pkg::chars_t   cfg_data;
  int                  mismatches;
  int                  chars_pending;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  idle_cycles = 0;
  logic                hold_active = 1'b0;
  event                hold_off_ev;

  sitrd_val_if in_ch ();
  sitrd_chr_if out_ch ();

  signed_integer_to_radix_digits uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  signed_integer_to_radix_digits_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    out_ch.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
  end

  always begin
    @(hold_off_ev);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_value(input logic signed [sitrd_pkg::IN_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for the text of every item, then give the block time to finish a dropped item
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_base(input sitrd_pkg::base_len_t len, input sitrd_pkg::chars_t lo,
                           input sitrd_pkg::chars_t hi);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_we    <= 1'b1;
    cfg_index <= sitrd_pkg::CFG_BASE_LENGTH;
    cfg_data  <= {junk[63:sitrd_pkg::BASE_LEN_W], len};
    @(negedge clk);
    cfg_index <= sitrd_pkg::CFG_CHARS_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= sitrd_pkg::CFG_CHARS_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [2*sitrd_pkg::CFG_W-1:0] random_digit_table(input int len);
    logic [2*sitrd_pkg::CFG_W-1:0] tbl;
    sitrd_pkg::char_t              c;
    bit                            used [0:255];
    tbl = {$urandom, $urandom, $urandom, $urandom};
    foreach (used[k]) used[k] = 1'b0;
    used[sitrd_pkg::CHAR_PLUS]  = 1'b1;
    used[sitrd_pkg::CHAR_MINUS] = 1'b1;
    for (int i = 0; i < len; i++) begin
      do c = sitrd_pkg::char_t'($urandom_range(sitrd_pkg::CHAR_TILDE, sitrd_pkg::CHAR_SPACE));
      while (used[c]);
      used[c] = 1'b1;
      tbl[i*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W] = c;
    end
    return tbl;
  endfunction

  // mostly good digit tables, some broken in one of the ways the block must reject
  task automatic load_random_base(output bit usable);
    logic [2*sitrd_pkg::CFG_W-1:0] tbl;
    int                            len;
    int                            j;
    len = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 2 : 16) : $urandom_range(16, 2);
    tbl = random_digit_table(len);
    usable = 1'b1;
    case ($urandom_range(11))
      0: begin
        len = $urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17);
        usable = 1'b0;
      end
      1: begin
        tbl = {$urandom, $urandom, $urandom, $urandom};
        len = $urandom_range(31);
        usable = 1'b0;
      end
      2: begin
        j = $urandom_range(len - 1);
        case ($urandom_range(4))
          0: tbl[j*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W] = sitrd_pkg::CHAR_PLUS;
          1: tbl[j*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W] = sitrd_pkg::CHAR_MINUS;
          2: tbl[j*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W] =
               sitrd_pkg::char_t'($urandom_range(8'h1F));
          3: tbl[j*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W] =
               sitrd_pkg::char_t'($urandom_range(8'hFF, 8'h7F));
          default: tbl[j*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W] =
                     tbl[((j + 1) % len)*sitrd_pkg::CHAR_W +: sitrd_pkg::CHAR_W];
        endcase
        usable = 1'b0;
      end
      default: ;
    endcase
    load_base(sitrd_pkg::base_len_t'(len), tbl[sitrd_pkg::CFG_W-1:0],
              tbl[2*sitrd_pkg::CFG_W-1:sitrd_pkg::CFG_W]);
  endtask

  function automatic logic signed [sitrd_pkg::IN_W-1:0] random_value();
    logic signed [sitrd_pkg::IN_W-1:0] v;
    case ($urandom_range(5))
      0, 1: v = $urandom;
      2: v = $urandom_range(600) - 300;
      3: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic directed_part();
    logic signed [sitrd_pkg::IN_W-1:0] dec_vals [8] = '{0, 1, -1, 32'h7FFF_FFFF,
                                                         32'h8000_0000, 9, -10, 123456789};
    sitrd_pkg::base_len_t bad_len [8] = '{5'd0, 5'd1, 5'd17, 5'd31, 5'd2, 5'd2, 5'd2, 5'd2};
    sitrd_pkg::chars_t    bad_lo  [8] = '{sitrd_pkg::RST_CHARS_LOW, sitrd_pkg::RST_CHARS_LOW,
                                          64'h3736353433323130, 64'h3736353433323130,
                                          64'h2D30, 64'h302B, 64'h7F1F, 64'h3030};
    sitrd_pkg::chars_t    bad_hi  [8] = '{sitrd_pkg::RST_CHARS_HIGH, sitrd_pkg::RST_CHARS_HIGH,
                                          64'h4645444342413938, 64'h4645444342413938,
                                          64'h0, 64'h0, 64'h0, 64'h0};
    // decimal table straight out of reset
    foreach (dec_vals[i]) send_value(dec_vals[i]);
    settle();
    // binary gives the longest text
    load_base(5'd2, 64'h3130, 64'h0);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(0);
    settle();
    load_base(5'd16, 64'h3736353433323130, 64'h4645444342413938);
    send_value(-1);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(255);
    settle();
    // space and tilde are the edges of the printable range
    load_base(5'd3, 64'h617E20, 64'h0);
    send_value(5);
    send_value(-8);
    settle();
    // too short, too long, sign characters, unprintable and repeated digits
    foreach (bad_len[i]) begin
      load_base(bad_len[i], bad_lo[i], bad_hi[i]);
      send_value(-5);
      settle();
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit squeeze);
    int sent;
    int n;
    bit usable;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      load_random_base(usable);
      if (squeeze && usable) begin
        // receiver holds off while items keep coming, so the input backs up
        -> hold_off_ev;
        squeeze = 1'b0;
      end
      n = usable ? $urandom_range(20, 8) : 4;
      repeat (n) send_value(random_value());
      if (usable) sent += n;
      settle();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = sitrd_pkg::CFG_BASE_LENGTH;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    send_idle_pct = 17;
    recv_idle_pct = 74;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_part();
    run_phase(17, 74, 1'b0);
    run_phase(74, 17, 1'b0);
    run_phase(0, 0, 1'b1);
    settle();
    if (mismatches == 0 && chars_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sitrd_pkg.sv
rtl/sitrd_val_if.sv
rtl/sitrd_chr_if.sv
rtl/signed_integer_to_radix_digits.sv
tb/sv/signed_integer_to_radix_digits_checker.sv
tb/sv/signed_integer_to_radix_digits_test.sv
